@@ hw/rtl/ddsm_pkg.sv @@
// Shared types, constants and the divide-by-ten helper for the decimal digit multiplier.
`default_nettype none

package ddsm_pkg;

	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned MULT_W  = 32;
	// Dividend of the digit datapath: carry plus nine times the multiplier
	localparam int unsigned SUM_W   = 36;
	// Narrow divider input: remainder times 2^18 plus the low half of the sum
	localparam int unsigned DIV_W   = 22;
	localparam int unsigned LO_W    = 18;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
	localparam logic [MULT_W-1:0]  MULT_RESET = 32'd1;
	// ceil(2^25 / 10): exact quotient for every input below 2^22
	localparam logic [DIV_W-1:0]   RECIP10    = 22'd3355444;
	localparam int unsigned        RECIP_SH   = 25;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [18:0]        q;
		logic [DIGIT_W-1:0] r;
	} div10_t;

	function automatic div10_t div10(input logic [DIV_W-1:0] v);
		logic [2*DIV_W-1:0] p;
		logic [18:0]        q;
		logic [DIV_W-1:0]   qx10;
		div10_t             res;
		p = {{DIV_W{1'b0}}, v} * {{DIV_W{1'b0}}, RECIP10};
		q = p[2*DIV_W-1:RECIP_SH];
		qx10 = {q, 3'b000} + {2'b00, q, 1'b0};
		res.q = q;
		res.r = DIGIT_W'(v - qx10);
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ddsm_front.sv @@
// Input side: accepts digits, clamps them to 0..9 and queues them for the datapath.
`default_nettype none

module ddsm_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [3:0]              digit_in,
	input  wire logic                    last_in,
	output logic                         q_valid,
	input  wire logic                    q_pop,
	output ddsm_pkg::item_t              q_item
);
	import ddsm_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      item_in;

	always_comb begin
		item_in.digit = (digit_in > DIGIT_MAX) ? DIGIT_MAX : digit_in;
		item_in.last  = last_in;
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	// pointers differ exactly when one entry is held
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/ddsm_back.sv @@
// Datapath side: multiply-add per digit, divide by ten, carry flush and result register.
`default_nettype none

module ddsm_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    multiplier_we,
	input  wire logic [31:0]             multiplier_wdata,
	input  wire logic                    q_valid,
	output logic                         q_pop,
	input  wire ddsm_pkg::item_t         q_item,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [3:0]                   digit_out,
	output logic                         last_out
);
	import ddsm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVA,
		ST_DIVB
	} state_t;

	state_t               state_q;
	logic [MULT_W-1:0]    mult_q;
	logic [MULT_W-1:0]    carry_q;
	logic [SUM_W-1:0]     x_q;
	logic [14:0]          qa_q;
	logic [DIGIT_W-1:0]   ra_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [DIGIT_W-1:0]   out_digit_q;
	logic                 out_last_q;

	logic [SUM_W-1:0]     sum;
	div10_t               div_a;
	div10_t               div_b;
	logic [MULT_W:0]      quot;
	logic                 quot_zero;
	logic                 emit;

	assign sum = SUM_W'(carry_q) + SUM_W'(mult_q) * SUM_W'(q_item.digit);

	// split the 36-bit dividend: high 18 bits first, then remainder joined to the low 18
	assign div_a     = div10(DIV_W'(x_q[SUM_W-1:LO_W]));
	assign div_b     = div10({ra_q, x_q[LO_W-1:0]});
	assign quot      = {qa_q, div_b.q[LO_W-1:0]};
	assign quot_zero = (quot == '0);

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign emit  = (state_q == ST_DIVB) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign digit_out = out_digit_q;
	assign last_out  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= MULT_RESET;
		end else if (multiplier_we) begin
			mult_q <= multiplier_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			carry_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						x_q     <= sum;
						last_q  <= q_item.last;
						state_q <= ST_DIVA;
					end
				end
				ST_DIVA: begin
					qa_q    <= div_a.q[14:0];
					ra_q    <= div_a.r;
					state_q <= ST_DIVB;
				end
				ST_DIVB: begin
					if (emit) begin
						if (last_q && !quot_zero) begin
							// flush the remaining carry digit by digit
							x_q     <= SUM_W'(quot[MULT_W-1:0]);
							state_q <= ST_DIVA;
						end else begin
							carry_q <= last_q ? '0 : quot[MULT_W-1:0];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
				out_digit_q <= div_b.r;
				out_last_q  <= last_q && quot_zero;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rem_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVB |-> ra_q <= DIGIT_MAX)
		else $error("divider remainder above nine");

	a_out_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_digit_q <= DIGIT_MAX)
		else $error("result digit above nine");

	a_diva_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVA |=> state_q == ST_DIVB)
		else $error("divider step skipped");

	// a held result must not be overwritten while the receiver stalls
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !emit)
		else $error("result overwritten under stall");

endmodule

`default_nettype wire

@@ hw/rtl/decimal_digit_scalar_multiplier_unit.sv @@
// Top level of the decimal digit scalar multiplier.
//
// Multiplies a decimal number by a 32-bit unsigned scalar. Digits enter on
// digit_in/last_in (valid/ready), least significant first, last_in set on
// the most significant digit; values above nine are taken as nine. Product
// digits leave on digit_out/last_out (valid/ready), least significant first,
// last_out set on the final one. The scalar is written through multiplier_we
// and multiplier_wdata; the user must write it only while no number is in
// flight, which the block itself does not enforce; it resets to one. In the
// datapath each input digit passes a multiply-add into x_q, then two
// divide-by-ten steps, each a reciprocal multiply of its own; each carry
// digit flushed after the last input digit passes the divide steps again.
// A two-entry queue keeps accepting digits while the datapath works, and one
// output register holds a result while the receiver stalls; the datapath
// waits when that register is full and the queue fills behind it. Reset
// empties the queue, clears the carry and drops any pending result.
`default_nettype none

module decimal_digit_scalar_multiplier_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        multiplier_we,
	input  wire logic [31:0] multiplier_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  digit_in,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       digit_out,
	output logic             last_out
);
	import ddsm_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	ddsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.digit_in (digit_in),
		.last_in  (last_in),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	ddsm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.multiplier_we    (multiplier_we),
		.multiplier_wdata (multiplier_wdata),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_item           (q_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.digit_out        (digit_out),
		.last_out         (last_out)
	);

endmodule

`default_nettype wire
